[src/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// types and constants shared by the instruction counter table
// ----------------------------------------------------------------------------
package ptc_pkg;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_START  = 3'd1,
        ACT_SWITCH = 3'd2,
        ACT_EXIT   = 3'd3,
        ACT_UNLOAD = 3'd4,
        ACT_DRAIN  = 3'd5,
        ACT_RESET  = 3'd6,
        ACT_GET    = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic clr;
        logic wr_all;
        logic wr_cnt;
    } cell_ctl_t;

    localparam int MAX_RESULTS = 16;
    localparam int NUM_W       = 5;
    localparam logic [31:0] IDLE_ID  = '1;
    localparam logic [63:0] IDLE_KEY = '1;
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_GET    = 1'b1;

endpackage

[src/ptc_cmd_if.sv]
// ----------------------------------------------------------------------------
// ptc_cmd_if / ptc_rsp_if
// valid/ready channels for commands and result beats
// ----------------------------------------------------------------------------
interface ptc_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] pid;
    logic [31:0] tid;
    logic        tracked;

    modport source (output valid, action, pid, tid, tracked, input ready);
    modport sink (input valid, action, pid, tid, tracked, output ready);
endinterface

interface ptc_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] out_pid;
    logic [31:0] out_tid;
    logic [63:0] count_value;
    logic        overflow_seen;
    logic        last;

    modport source (output valid, kind, out_pid, out_tid, count_value, overflow_seen, last,
                    input ready);
    modport sink (input valid, kind, out_pid, out_tid, count_value, overflow_seen, last,
                  output ready);
endinterface

[src/per_thread_instruction_counter_table.sv]
// ----------------------------------------------------------------------------
// per_thread_instruction_counter_table
// retired instruction counts per thread with a table of saved counts
// ----------------------------------------------------------------------------
// cmd carries one command beat; rsp carries result beats, last marks the
// final beat of a command. cfg_we/cfg_wdata write filter_on (filter_reg);
// the user must do so only while idle, as the block does not enforce it.
// tick, start, reset and get finish in ST_IDLE and can follow back to back
// while rsp does not stall; get writes its reply into the output register.
// switch is accepted in ST_IDLE; in ST_EXEC the row of cells then saves the
// live count and finds the new key in the same pass. exit, unload and drain
// save the live count in ST_EXEC, scan the table one slot a cycle in ST_SCAN
// and flush the last record in ST_FLUSH. records leave through a one-beat
// staging register and the output register. a stalled rsp holds the scan
// and, through the output register, cmd. reset clears the live count; rst_n
// also idles the key, empties the table and clears the flags.
// ----------------------------------------------------------------------------
module per_thread_instruction_counter_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    ptc_cmd_if.sink   cmd,
    ptc_rsp_if.source rsp
);
    import ptc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    state_t             state_reg, state_next;
    logic               filter_reg;
    logic [31:0]        live_pid_reg, live_pid_next;
    logic [31:0]        live_tid_reg, live_tid_next;
    logic [63:0]        live_count_reg, live_count_next;
    logic               enabled_reg, enabled_next;
    logic               dropped_reg, dropped_next;
    action_t            op_reg, op_next;
    logic [31:0]        op_pid_reg, op_pid_next;
    logic [31:0]        op_tid_reg, op_tid_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic               pend_reg, pend_next;
    logic [63:0]        pend_key_reg, pend_key_next;
    logic [63:0]        pend_cnt_reg, pend_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic [31:0]        out_pid_reg, out_pid_next;
    logic [31:0]        out_tid_reg, out_tid_next;
    logic [63:0]        out_cnt_reg, out_cnt_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic               acc;
    logic               save_en;
    logic               scan_adv;
    logic               scan_erase;
    logic               sc_match;
    logic               sc_emit;
    logic [63:0]        sc_key;
    logic [63:0]        sc_cnt;
    logic               sc_valid;
    logic [63:0]        live_key;
    logic [63:0]        op_key;

    cell_ctl_t          ctl       [TABLE_DEPTH];
    logic               taken_c   [TABLE_DEPTH+1];
    logic               hit_c     [TABLE_DEPTH+1];
    logic [63:0]        load_c    [TABLE_DEPTH+1];
    logic               match_a   [TABLE_DEPTH];
    logic               first_free[TABLE_DEPTH];
    logic               c_valid   [TABLE_DEPTH];
    logic [63:0]        c_key     [TABLE_DEPTH];
    logic [63:0]        c_cnt     [TABLE_DEPTH];

    assign live_key   = {live_pid_reg, live_tid_reg};
    assign op_key     = {op_pid_reg, op_tid_reg};
    assign taken_c[0] = 1'b0;
    assign hit_c[0]   = 1'b0;
    assign load_c[0]  = '0;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && out_free;
    assign acc       = cmd.valid && cmd.ready;

    assign save_en = (state_reg == ST_EXEC) &&
                     ((op_reg != ACT_SWITCH) || (op_key != live_key));

    assign sc_valid   = c_valid[idx_reg];
    assign sc_key     = c_key[idx_reg];
    assign sc_cnt     = c_cnt[idx_reg];
    assign scan_erase = (op_reg != ACT_DRAIN);

    always_comb
    begin
        case (op_reg)
            ACT_EXIT:   sc_match = sc_valid && (sc_key == op_key);
            ACT_UNLOAD: sc_match = sc_valid && (sc_key[63:32] == op_pid_reg);
            default:    sc_match = sc_valid;
        endcase
    end

    assign sc_emit  = sc_match && (sc_cnt != '0) && (sc_key != IDLE_KEY) &&
                      (num_reg < NUM_W'(MAX_RESULTS));
    assign scan_adv = (state_reg == ST_SCAN) && !(sc_emit && pend_reg && !out_free);

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            always_comb
            begin
                ctl[gi].clr    = (save_en && match_a[gi] && (live_count_reg == '0)) ||
                                 (scan_adv && scan_erase && sc_match &&
                                  (idx_reg == IDX_W'(gi)));
                ctl[gi].wr_cnt = save_en && match_a[gi] && (live_count_reg != '0);
                ctl[gi].wr_all = save_en && !hit_c[TABLE_DEPTH] &&
                                 (live_count_reg != '0) && first_free[gi];
            end

            ptc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl[gi]),
                .wr_key     (live_key),
                .wr_count   (live_count_reg),
                .key_a      (live_key),
                .key_b      (op_key),
                .taken_in   (taken_c[gi]),
                .taken_out  (taken_c[gi+1]),
                .hit_a_in   (hit_c[gi]),
                .hit_a_out  (hit_c[gi+1]),
                .load_in    (load_c[gi]),
                .load_out   (load_c[gi+1]),
                .match_a    (match_a[gi]),
                .first_free (first_free[gi]),
                .valid      (c_valid[gi]),
                .key        (c_key[gi]),
                .count      (c_cnt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        live_pid_next   = live_pid_reg;
        live_tid_next   = live_tid_reg;
        live_count_next = live_count_reg;
        enabled_next    = enabled_reg;
        dropped_next    = dropped_reg;
        op_next         = op_reg;
        op_pid_next     = op_pid_reg;
        op_tid_next     = op_tid_reg;
        idx_next        = idx_reg;
        num_next        = num_reg;
        pend_next       = pend_reg;
        pend_key_next   = pend_key_reg;
        pend_cnt_next   = pend_cnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_kind_next   = out_kind_reg;
        out_pid_next    = out_pid_reg;
        out_tid_next    = out_tid_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;

        if (save_en && !hit_c[TABLE_DEPTH] && (live_count_reg != '0) &&
            taken_c[TABLE_DEPTH] == 1'b0)
            dropped_next = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    op_next     = action_t'(cmd.action);
                    op_pid_next = cmd.pid;
                    op_tid_next = cmd.tid;
                    case (action_t'(cmd.action))
                        ACT_TICK:
                            if (enabled_reg)
                                live_count_next = live_count_reg + 64'd1;
                        ACT_START:
                            enabled_next = filter_reg ? cmd.tracked : 1'b1;
                        ACT_RESET:
                            live_count_next = '0;
                        ACT_GET:
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_GET;
                            out_pid_next   = live_pid_reg;
                            out_tid_next   = live_tid_reg;
                            out_cnt_next   = live_count_reg;
                            out_last_next  = 1'b1;
                        end
                        default:
                            state_next = ST_EXEC;
                    endcase
                end
            end
            ST_EXEC:
            begin
                if (op_reg == ACT_SWITCH)
                begin
                    if (save_en)
                    begin
                        live_count_next = load_c[TABLE_DEPTH];
                        live_pid_next   = op_pid_reg;
                        live_tid_next   = op_tid_reg;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    live_count_next = '0;
                    live_pid_next   = IDLE_ID;
                    live_tid_next   = IDLE_ID;
                    idx_next        = '0;
                    num_next        = '0;
                    pend_next       = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_adv)
                begin
                    if (sc_emit)
                    begin
                        if (pend_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_RECORD;
                            out_pid_next   = pend_key_reg[63:32];
                            out_tid_next   = pend_key_reg[31:0];
                            out_cnt_next   = pend_cnt_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_next     = 1'b1;
                        pend_key_next = sc_key;
                        pend_cnt_next = sc_cnt;
                        num_next      = num_reg + NUM_W'(1);
                    end
                    if (idx_reg == IDX_W'(TABLE_DEPTH - 1))
                        state_next = ST_FLUSH;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (!pend_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_RECORD;
                    out_pid_next   = pend_key_reg[63:32];
                    out_tid_next   = pend_key_reg[31:0];
                    out_cnt_next   = pend_cnt_reg;
                    out_last_next  = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            filter_reg     <= 1'b0;
            live_pid_reg   <= IDLE_ID;
            live_tid_reg   <= IDLE_ID;
            live_count_reg <= '0;
            enabled_reg    <= 1'b0;
            dropped_reg    <= 1'b0;
            idx_reg        <= '0;
            num_reg        <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            op_reg         <= ACT_TICK;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
                filter_reg <= cfg_wdata;
            live_pid_reg   <= live_pid_next;
            live_tid_reg   <= live_tid_next;
            live_count_reg <= live_count_next;
            enabled_reg    <= enabled_next;
            dropped_reg    <= dropped_next;
            idx_reg        <= idx_next;
            num_reg        <= num_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            op_reg         <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_pid_reg   <= op_pid_next;
        op_tid_reg   <= op_tid_next;
        pend_key_reg <= pend_key_next;
        pend_cnt_reg <= pend_cnt_next;
        out_kind_reg <= out_kind_next;
        out_pid_reg  <= out_pid_next;
        out_tid_reg  <= out_tid_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.out_pid       = out_pid_reg;
    assign rsp.out_tid       = out_tid_reg;
    assign rsp.count_value   = out_cnt_reg;
    assign rsp.overflow_seen = dropped_reg;
    assign rsp.last          = out_last_reg;

endmodule

[src/ptc_cell.sv]
// ----------------------------------------------------------------------------
// ptc_cell
// one table slot; passes free, hit and load data on to its neighbor
// ----------------------------------------------------------------------------
module ptc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ptc_pkg::cell_ctl_t  ctl,
    input  logic [63:0]         wr_key,
    input  logic [63:0]         wr_count,
    input  logic [63:0]         key_a,
    input  logic [63:0]         key_b,
    input  logic                taken_in,
    output logic                taken_out,
    input  logic                hit_a_in,
    output logic                hit_a_out,
    input  logic [63:0]         load_in,
    output logic [63:0]         load_out,
    output logic                match_a,
    output logic                first_free,
    output logic                valid,
    output logic [63:0]         key,
    output logic [63:0]         count
);
    import ptc_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] key_reg;
    logic [63:0] count_reg;
    logic        match_b;

    assign match_a    = valid_reg && (key_reg == key_a);
    assign match_b    = valid_reg && (key_reg == key_b);
    assign first_free = !valid_reg && !taken_in;
    assign taken_out  = taken_in || !valid_reg;
    assign hit_a_out  = hit_a_in || match_a;
    assign load_out   = match_b ? count_reg : load_in;
    assign valid      = valid_reg;
    assign key        = key_reg;
    assign count      = count_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clr)
            valid_next = 1'b0;
        if (ctl.wr_all)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_all)
            key_reg <= wr_key;
        if (ctl.wr_all || ctl.wr_cnt)
            count_reg <= wr_count;
    end

endmodule

[src/ptc_checker.sv]
// ----------------------------------------------------------------------------
// ptc_checker
// port-level checks on the counter table, bound to the top level
// ----------------------------------------------------------------------------
module ptc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [2:0] cmd_action,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_kind,
    input logic       rsp_last,
    input logic       rsp_overflow
);
    import ptc_pkg::*;

    a_get_reply: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_action == ACT_GET) |=> rsp_valid && rsp_kind)
        else $error("get beat without reply");

    a_get_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind |-> rsp_last)
        else $error("get reply not marked last");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rsp_overflow) |-> rsp_overflow)
        else $error("overflow flag cleared");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped while stalled");

endmodule

bind per_thread_instruction_counter_table ptc_checker u_ptc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .cmd_action   (cmd.action),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_kind     (rsp.kind),
    .rsp_last     (rsp.last),
    .rsp_overflow (rsp.overflow_seen)
);

[dv/per_thread_instruction_counter_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_thread_instruction_counter_table_tb
// self-checking bench for the per-thread instruction counter table
// ----------------------------------------------------------------------------
// Commands come from a queue of pending beats and go through a valid/ready
// driver. Each accepted command runs through a behavioral copy of the table,
// which queues the records it should emit. A monitor compares every result
// beat, field by field, with the oldest queued record. Both sides idle at
// random. Once the receiver holds off long enough to stall the command side.
// The run covers both filter settings and ends with a stretch of no idling.
// ----------------------------------------------------------------------------
module per_thread_instruction_counter_table_tb;
    import ptc_pkg::*;

    localparam int DEPTH     = 16;
    localparam int CYC_LIMIT = 400000;
    localparam int SETTLE    = 2 * (DEPTH + 8);

    typedef struct {
        action_t     act;
        logic [31:0] pid;
        logic [31:0] tid;
        logic        tracked;
    } cmd_beat_t;

    typedef struct {
        logic        kind;
        logic [31:0] pid;
        logic [31:0] tid;
        logic [63:0] cnt;
        logic        ovf;
        logic        is_last;
    } count_rec_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ptc_cmd_if cmd ();
    ptc_rsp_if rsp ();

    per_thread_instruction_counter_table #(.TABLE_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd.sink),
        .rsp       (rsp.source)
    );

    cmd_beat_t  pend_cmds[$];
    count_rec_t exp_recs[$];

    // mirror of the block state
    logic        filt;
    logic [31:0] cur_pid;
    logic [31:0] cur_tid;
    logic [63:0] cur_cnt;
    logic        cnt_en;
    logic        slot_v[DEPTH];
    logic [63:0] slot_k[DEPTH];
    logic [63:0] slot_c[DEPTH];
    logic        dropped;

    int  mismatches;
    int  cycles;
    bit  idle_on;
    int  hold_cycles;
    int  cmd_gap;
    int  rsp_gap;

    always #5 clk = ~clk;

    function automatic int find_key(logic [63:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (slot_v[i] && slot_k[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void save_live();
        logic [63:0] k;
        int s;
        k = {cur_pid, cur_tid};
        s = find_key(k);
        if (s >= 0) begin
            if (cur_cnt == 0)
                slot_v[s] = 1'b0;
            else
                slot_c[s] = cur_cnt;
            return;
        end
        if (cur_cnt == 0)
            return;
        for (int i = 0; i < DEPTH; i++)
            if (!slot_v[i]) begin
                slot_v[i] = 1'b1;
                slot_k[i] = k;
                slot_c[i] = cur_cnt;
                return;
            end
        dropped = 1'b1;
    endfunction

    function automatic void table_step(cmd_beat_t c);
        count_rec_t r;
        int n;
        int s;
        bit hit;
        n = 0;
        case (c.act)
            ACT_TICK:  if (cnt_en) cur_cnt = cur_cnt + 64'd1;
            ACT_START: cnt_en = filt ? c.tracked : 1'b1;
            ACT_SWITCH:
                if (c.pid != cur_pid || c.tid != cur_tid) begin
                    save_live();
                    s = find_key({c.pid, c.tid});
                    cur_cnt = (s >= 0) ? slot_c[s] : 64'd0;
                    cur_pid = c.pid;
                    cur_tid = c.tid;
                end
            ACT_RESET: cur_cnt = '0;
            ACT_GET:
            begin
                r = '{KIND_GET, cur_pid, cur_tid, cur_cnt, dropped, 1'b1};
                exp_recs = {exp_recs, r};
            end
            default:
            begin
                save_live();
                cur_cnt = '0;
                cur_pid = IDLE_ID;
                cur_tid = IDLE_ID;
                for (int i = 0; i < DEPTH; i++) begin
                    if (!slot_v[i])
                        continue;
                    if (c.act == ACT_EXIT)
                        hit = (slot_k[i] == {c.pid, c.tid});
                    else if (c.act == ACT_UNLOAD)
                        hit = (slot_k[i][63:32] == c.pid);
                    else
                        hit = 1'b1;
                    if (!hit)
                        continue;
                    if (slot_c[i] != 0 && slot_k[i] != IDLE_KEY && n < MAX_RESULTS) begin
                        r = '{KIND_RECORD, slot_k[i][63:32], slot_k[i][31:0], slot_c[i],
                              dropped, 1'b0};
                        exp_recs = {exp_recs, r};
                        n++;
                    end
                    if (c.act != ACT_DRAIN)
                        slot_v[i] = 1'b0;
                end
                if (n > 0)
                    exp_recs[exp_recs.size() - 1].is_last = 1'b1;
            end
        endcase
    endfunction

    // command driver
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cmd.valid && cmd.ready) begin
                table_step(pend_cmds[0]);
                void'(pend_cmds.pop_front());
            end
            // a waiting beat stays on the bus until accepted
            if (!cmd.valid || cmd.ready) begin
                if (cmd_gap > 0) begin
                    cmd_gap <= cmd_gap - 1;
                    cmd.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 11) == 0) begin
                    cmd_gap <= $urandom_range(0, 8);
                    cmd.valid <= 1'b0;
                end else if (pend_cmds.size() > 0) begin
                    cmd.valid   <= 1'b1;
                    cmd.action  <= pend_cmds[0].act;
                    cmd.pid     <= pend_cmds[0].pid;
                    cmd.tid     <= pend_cmds[0].tid;
                    cmd.tracked <= pend_cmds[0].tracked;
                end else begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // result monitor
    always @(posedge clk)
    begin
        count_rec_t e;
        if (rst_n) begin
            if (rsp.valid && rsp.ready) begin
                if (exp_recs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat pid %h tid %h cnt %h",
                                 rsp.out_pid, rsp.out_tid, rsp.count_value);
                end else begin
                    e = exp_recs.pop_front();
                    if (rsp.kind !== e.kind || rsp.out_pid !== e.pid || rsp.out_tid !== e.tid
                        || rsp.count_value !== e.cnt || rsp.overflow_seen !== e.ovf
                        || rsp.last !== e.is_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp k%b %h %h %h o%b l%b got k%b %h %h %h o%b l%b",
                                     e.kind, e.pid, e.tid, e.cnt, e.ovf, e.is_last,
                                     rsp.kind, rsp.out_pid, rsp.out_tid, rsp.count_value,
                                     rsp.overflow_seen, rsp.last);
                    end
                end
            end
            if (hold_cycles > 0) begin
                rsp.ready <= 1'b0;
            end else if (rsp_gap > 0) begin
                rsp_gap <= rsp_gap - 1;
                rsp.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                rsp_gap <= $urandom_range(0, 8);
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("per_thread_instruction_counter_table verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return IDLE_ID;
            1:       return $urandom();
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic void add(action_t a, logic [31:0] p, logic [31:0] t, logic trk);
        cmd_beat_t c;
        c = '{a, p, t, trk};
        pend_cmds = {pend_cmds, c};
    endfunction

    task automatic add_random(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 35)
                add(ACT_SWITCH, pick_id(), pick_id(), rand_bit());
            else if (k < 65)
                add(ACT_TICK, $urandom(), $urandom(), rand_bit());
            else if (k < 72)
                add(ACT_START, $urandom(), $urandom(), rand_bit());
            else if (k < 78)
                add(ACT_EXIT, pick_id(), pick_id(), rand_bit());
            else if (k < 83)
                add(ACT_UNLOAD, pick_id(), pick_id(), rand_bit());
            else if (k < 87)
                add(ACT_DRAIN, $urandom(), $urandom(), rand_bit());
            else if (k < 90)
                add(ACT_RESET, $urandom(), $urandom(), rand_bit());
            else
                add(ACT_GET, $urandom(), $urandom(), rand_bit());
        end
    endtask

    task automatic settle();
        while (pend_cmds.size() > 0 || exp_recs.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_filter(logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        filt = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        cmd.valid = 1'b0;
        cmd.action = ACT_TICK;
        cmd.pid = '0;
        cmd.tid = '0;
        cmd.tracked = 1'b0;
        rsp.ready = 1'b0;
        filt = 1'b0;
        cur_pid = IDLE_ID;
        cur_tid = IDLE_ID;
        cur_cnt = '0;
        cnt_en = 1'b0;
        dropped = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            slot_v[i] = 1'b0;
        mismatches = 0;
        cycles = 0;
        idle_on = 1'b1;
        hold_cycles = 0;
        cmd_gap = 0;
        rsp_gap = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_filter(1'b0);
        // directed beats
        add(ACT_TICK, '0, '0, 1'b0);
        add(ACT_GET, '0, '0, 1'b0);
        add(ACT_START, '0, '0, 1'b0);
        add(ACT_TICK, '0, '0, 1'b0);
        add(ACT_TICK, '0, '0, 1'b0);
        add(ACT_DRAIN, '0, '0, 1'b0);
        add(ACT_SWITCH, '0, '0, 1'b1);
        add(ACT_TICK, '1, '1, 1'b1);
        add(ACT_SWITCH, '1, 32'd5, 1'b0);
        add(ACT_TICK, '0, '0, 1'b0);
        add(ACT_TICK, '0, '0, 1'b0);
        add(ACT_SWITCH, '1, 32'd5, 1'b0);
        add(ACT_GET, '0, '0, 1'b0);
        add(ACT_SWITCH, '0, '0, 1'b0);
        add(ACT_GET, '0, '0, 1'b0);
        add(ACT_RESET, '0, '0, 1'b0);
        add(ACT_SWITCH, IDLE_ID, IDLE_ID, 1'b0);
        add(ACT_TICK, '0, '0, 1'b0);
        add(ACT_DRAIN, '0, '0, 1'b0);
        add(ACT_EXIT, '0, '0, 1'b0);
        add(ACT_UNLOAD, '1, '0, 1'b0);
        add(ACT_EXIT, IDLE_ID, IDLE_ID, 1'b0);
        add(ACT_GET, '0, '0, 1'b0);
        settle();

        // fill past the table depth to force a dropped count
        write_filter(1'b1);
        add(ACT_START, '0, '0, 1'b1);
        for (int i = 0; i < DEPTH + 3; i++) begin
            add(ACT_SWITCH, 32'd7, i, 1'b0);
            add(ACT_TICK, '0, '0, 1'b0);
        end
        add(ACT_DRAIN, '0, '0, 1'b0);
        add(ACT_UNLOAD, 32'd7, '0, 1'b0);
        add(ACT_START, '0, '0, 1'b0);
        add_random(55);
        hold_cycles = 400;
        settle();

        write_filter(1'b0);
        add_random(70);
        settle();

        write_filter(1'b1);
        add_random(40);
        settle();

        idle_on = 1'b0;
        write_filter(1'b0);
        add_random(50);
        settle();

        if (mismatches == 0 && exp_recs.size() == 0)
            $display("per_thread_instruction_counter_table verification clean");
        else
            $display("per_thread_instruction_counter_table verification failed");
        $finish;
    end
endmodule
